>>> design/idw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the inverse-distance interpolator.
// No dependencies; imported by every module of the block.
package idw_pkg;

    localparam int SourceDepth = 256;
    localparam int CNT_W = $clog2(SourceDepth + 1);
    localparam int IDX_W = (SourceDepth > 1) ? $clog2(SourceDepth) : 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_HIT  = 2'd1;
    localparam logic [1:0] SEL_DIV  = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       add;
        logic       qstart;
        logic       rd;
        logic       sq;
        logic       sum;
        logic       norm_step;
        logic       log_init;
        logic       log_step;
        logic       expc;
        logic       exp_step;
        logic       acc1;
        logic       acc2;
        logic       div_init;
        logic       div_step;
        logic       finish;
        logic [1:0] fin_sel;
        logic [1:0] fin_status;
        logic [3:0] step;
    } idw_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cnt_zero;
        logic       cnt_full;
        logic       idx_last;
        logic       dzero;
        logic       norm_done;
        logic       out_free;
    } idw_stat_t;

    function automatic logic [30:0] exp2_tab(input logic [3:0] k);
        logic [30:0] t;
        case (k)
            4'd0:    t = 31'd1518500250;
            4'd1:    t = 31'd1276901417;
            4'd2:    t = 31'd1170923762;
            4'd3:    t = 31'd1121280437;
            4'd4:    t = 31'd1097253708;
            4'd5:    t = 31'd1085434105;
            4'd6:    t = 31'd1079572139;
            4'd7:    t = 31'd1076653034;
            4'd8:    t = 31'd1075196443;
            4'd9:    t = 31'd1074468887;
            4'd10:   t = 31'd1074105292;
            4'd11:   t = 31'd1073923544;
            4'd12:   t = 31'd1073832680;
            4'd13:   t = 31'd1073787251;
            4'd14:   t = 31'd1073764537;
            default: t = 31'd1073753181;
        endcase
        return t;
    endfunction

endpackage

>>> design/idw_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the interpolator.
// Depends on idw_pkg; drives the datapath through idw_cmd_t.
module idw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  idw_pkg::idw_stat_t st,
    output idw_pkg::idw_cmd_t  cmd
);
    import idw_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_NORM = 4'd5;
    localparam logic [3:0] S_LOG  = 4'd6;
    localparam logic [3:0] S_EXPC = 4'd7;
    localparam logic [3:0] S_EXP  = 4'd8;
    localparam logic [3:0] S_ACC1 = 4'd9;
    localparam logic [3:0] S_ACC2 = 4'd10;
    localparam logic [3:0] S_DIVI = 4'd11;
    localparam logic [3:0] S_DIV  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic [1:0] fsel_reg, fsel_next;
    logic [1:0] fstat_reg, fstat_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        fsel_next  = fsel_reg;
        fstat_next = fstat_reg;
        cmd            = '0;
        cmd.step       = step_reg[3:0];
        cmd.fin_sel    = fsel_reg;
        cmd.fin_status = fstat_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                fsel_next  = SEL_ZERO;
                fstat_next = ST_OK;
                state_next = S_FIN;
                case (st.op)
                    OP_CLEAR: cmd.clear = 1'b1;
                    OP_ADD: begin
                        if (st.cnt_full) begin
                            fstat_next = ST_FULL;
                        end else begin
                            cmd.add = 1'b1;
                        end
                    end
                    OP_QUERY: begin
                        if (st.cnt_zero) begin
                            fstat_next = ST_EMPTY;
                        end else begin
                            cmd.qstart = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.sq     = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_NORM;
            end
            S_NORM: begin
                if (st.dzero) begin
                    fsel_next  = SEL_HIT;
                    fstat_next = ST_OK;
                    state_next = S_FIN;
                end else if (st.norm_done) begin
                    cmd.log_init = 1'b1;
                    step_next    = '0;
                    state_next   = S_LOG;
                end else begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_LOG: begin
                cmd.log_step = 1'b1;
                step_next    = step_reg + 6'd1;
                if (step_reg == 6'd15) begin
                    step_next  = '0;
                    state_next = S_EXPC;
                end
            end
            S_EXPC: begin
                cmd.expc   = 1'b1;
                step_next  = '0;
                state_next = S_EXP;
            end
            S_EXP: begin
                cmd.exp_step = 1'b1;
                step_next    = step_reg + 6'd1;
                if (step_reg == 6'd15) begin
                    step_next  = '0;
                    state_next = S_ACC1;
                end
            end
            S_ACC1: begin
                cmd.acc1   = 1'b1;
                state_next = S_ACC2;
            end
            S_ACC2: begin
                cmd.acc2   = 1'b1;
                state_next = st.idx_last ? S_DIVI : S_RD;
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 6'd1;
                if (step_reg == 6'd63) begin
                    fsel_next  = SEL_DIV;
                    fstat_next = ST_OK;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            fsel_reg  <= SEL_ZERO;
            fstat_reg <= ST_OK;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fsel_reg  <= fsel_next;
            fstat_reg <= fstat_next;
        end
    end

endmodule

>>> design/idw_dp.sv
`timescale 1ns / 1ps
// Datapath of the interpolator: source table, distance, log2/exp2 units,
// block-exponent sums, serial divider and output register. Depends on idw_pkg.
module idw_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  idw_pkg::idw_cmd_t  cmd,
    output idw_pkg::idw_stat_t st,
    input  logic [1:0]        s_tuser,
    input  logic [95:0]       s_tdata,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [2:0]        m_tuser
);
    import idw_pkg::*;

    logic [95:0]        mem [SourceDepth];
    logic [95:0]        rd_reg;
    logic [1:0]         op_reg;
    logic [95:0]        item_reg;
    logic [7:0]         power_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [63:0]        sx_reg, sy_reg;
    logic [63:0]        m_reg;
    logic               carry_reg, dzero_reg;
    logic [5:0]         n_reg;
    logic [30:0]        x_reg;
    logic [15:0]        frac_reg;
    logic signed [17:0] ee_reg, emax_reg;
    logic [15:0]        f_reg;
    logic [30:0]        r_reg;
    logic signed [48:0] prod_reg;
    logic               first_reg;
    logic signed [63:0] num_reg;
    logic [24:0]        den_reg;
    logic [63:0]        a_reg;
    logic [25:0]        rem_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic [2:0]         out_user_reg;

    logic signed [32:0] dx, dy;
    logic [31:0]        ax, ay;
    logic [64:0]        dsum;
    logic [61:0]        xsq;
    logic signed [7:0]  lint;
    logic signed [23:0] lval;
    logic signed [33:0] pw, ew;
    logic [61:0]        rprod;
    logic [15:0]        mant;
    logic signed [18:0] grow, gap;
    logic [5:0]         sh_grow, sh_gap;
    logic [25:0]        trial;
    logic signed [64:0] qs;
    logic [31:0]        div_res;

    assign st.op        = op_reg;
    assign st.cnt_zero  = (cnt_reg == '0);
    assign st.cnt_full  = (cnt_reg == CNT_W'(SourceDepth));
    assign st.idx_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign st.dzero     = dzero_reg;
    assign st.norm_done = m_reg[63];
    assign st.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        dx    = $signed({item_reg[31], item_reg[31:0]}) - $signed({rd_reg[31], rd_reg[31:0]});
        dy    = $signed({item_reg[63], item_reg[63:32]})
              - $signed({rd_reg[63], rd_reg[63:32]});
        ax    = dx[32] ? 32'(-dx) : dx[31:0];
        ay    = dy[32] ? 32'(-dy) : dy[31:0];
        dsum  = {1'b0, sx_reg} + {1'b0, sy_reg};
        xsq   = 62'({31'd0, x_reg} * {31'd0, x_reg});
        lint  = $signed({2'b00, n_reg}) + $signed({7'd0, carry_reg}) - 8'sd32;
        lval  = $signed({lint, frac_reg});
        pw    = 34'(lval * $signed({1'b0, power_reg}));
        ew    = (-pw) >>> 5;
        rprod = 62'({31'd0, r_reg} * {31'd0, exp2_tab(cmd.step)}) + 62'd536870912;
        mant  = r_reg[30:15];
        grow  = 19'(ee_reg) - 19'(emax_reg);
        gap   = 19'(emax_reg) - 19'(ee_reg);
        sh_grow = (grow > 19'sd63) ? 6'd63 : grow[5:0];
        sh_gap  = (gap > 19'sd63) ? 6'd63 : gap[5:0];
        trial = {rem_reg[24:0], a_reg[63]};
        qs    = neg_reg ? -$signed({1'b0, a_reg}) : $signed({1'b0, a_reg});
        if (qs > 65'sd2147483647) begin
            div_res = 32'h7FFF_FFFF;
        end else if (qs < -65'sd2147483648) begin
            div_res = 32'h8000_0000;
        end else begin
            div_res = qs[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add) begin
            mem[cnt_reg[IDX_W-1:0]] <= item_reg;
        end
        if (cmd.rd) begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg     <= 8'd16;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                power_reg <= cfg_wdata;
            end
            if (cmd.clear) begin
                cnt_reg <= '0;
            end else if (cmd.add) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tuser;
            item_reg <= s_tdata;
        end
        if (cmd.qstart) begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
            num_reg   <= '0;
            den_reg   <= '0;
        end
        if (cmd.sq) begin
            sx_reg <= 64'(ax * ax);
            sy_reg <= 64'(ay * ay);
        end
        if (cmd.sum) begin
            dzero_reg <= (dsum == '0);
            carry_reg <= dsum[64];
            m_reg     <= dsum[64] ? dsum[64:1] : dsum[63:0];
            n_reg     <= 6'd63;
        end
        if (cmd.norm_step) begin
            if (m_reg[63:56] == 8'd0) begin
                m_reg <= m_reg << 8;
                n_reg <= n_reg - 6'd8;
            end else begin
                m_reg <= m_reg << 1;
                n_reg <= n_reg - 6'd1;
            end
        end
        if (cmd.log_init) begin
            x_reg    <= m_reg[63:33];
            frac_reg <= '0;
        end
        if (cmd.log_step) begin
            if (xsq[61]) begin
                x_reg    <= xsq[61:31];
                frac_reg <= {frac_reg[14:0], 1'b1};
            end else begin
                x_reg    <= xsq[60:30];
                frac_reg <= {frac_reg[14:0], 1'b0};
            end
        end
        if (cmd.expc) begin
            ee_reg <= ew[33:16];
            f_reg  <= ew[15:0];
            r_reg  <= 31'd1073741824;
        end
        if (cmd.exp_step && f_reg[4'd15 - cmd.step]) begin
            r_reg <= rprod[60:30];
        end
        if (cmd.acc1) begin
            prod_reg <= 49'($signed({1'b0, mant}) * $signed(rd_reg[95:64]));
            if (first_reg) begin
                emax_reg  <= ee_reg;
                first_reg <= 1'b0;
            end else if (grow > 19'sd0) begin
                num_reg  <= num_reg >>> sh_grow;
                den_reg  <= den_reg >> sh_grow;
                emax_reg <= ee_reg;
            end
        end
        if (cmd.acc2) begin
            num_reg <= num_reg + (64'(prod_reg) >>> sh_gap);
            den_reg <= den_reg + 25'({9'd0, mant} >> sh_gap);
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.div_init) begin
            a_reg   <= num_reg[63] ? 64'(-num_reg) : num_reg;
            neg_reg <= num_reg[63];
            rem_reg <= '0;
            if (den_reg == '0) begin
                den_reg <= 25'd1;
            end
        end
        if (cmd.div_step) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= trial - {1'b0, den_reg};
                a_reg   <= {a_reg[62:0], 1'b1};
            end else begin
                rem_reg <= trial;
                a_reg   <= {a_reg[62:0], 1'b0};
            end
        end
        if (cmd.finish) begin
            out_user_reg <= {cmd.fin_sel == SEL_HIT, cmd.fin_status};
            case (cmd.fin_sel)
                SEL_HIT: out_data_reg <= rd_reg[95:64];
                SEL_DIV: out_data_reg <= div_res;
                default: out_data_reg <= '0;
            endcase
        end
    end

endmodule

>>> design/inverse_distance_interpolator.sv
`timescale 1ns / 1ps
// Top level of the Shepard inverse-distance-weighting interpolator.
// Depends on idw_pkg, idw_ctrl and idw_dp.
//
// Input transactions carry op in s_tuser and the coordinates and value in
// s_tdata. Op 0 clears the source table, op 1 adds a source, op 2 queries.
// Every input transaction yields exactly one output transaction: the result
// value in m_tdata, and status and the exact-hit flag in m_tuser.
// The power register is written through cfg_we and cfg_wdata while idle; the
// user must keep to that, as the block itself has no guard for it. Clear and
// add pass from acceptance through dispatch and the finish state to the
// output register. A query walks the stored sources in turn (table read,
// squaring, sum, a normalize, 16 log2 steps, an exponent step, 16 exp2 steps
// and two accumulate steps) after dispatch, then runs the 64-step bit-serial
// division and output register; an exact hit stops the walk at that source.
// One item is in work at a time; s_tready is high while the controller idles.
// The result register lets the next item be taken while a result waits; if
// the receiver stalls, a finished item waits until the register frees.
// Synchronous active-low reset empties the table, sets power to 1.0 and
// drops any pending result.
module inverse_distance_interpolator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // coord_x, coord_y, sample_value
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value
    output logic [2:0]  m_tuser,   // status, exact_hit
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import idw_pkg::*;

    idw_cmd_t  cmd;
    idw_stat_t st;

    idw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    idw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> design/idw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the interpolator and the bind that attaches them.
// Depends on idw_pkg and the top level's ports.
module idw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import idw_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result dropped while stalled.");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("Result changed while stalled.");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == ST_OK || m_tuser[1:0] == ST_FULL ||
                      m_tuser[1:0] == ST_EMPTY))
        else $error("Undefined status code.");
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
        else $error("Exact hit with an error status.");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != ST_OK |-> m_tdata == 32'd0)
        else $error("Error result carries a nonzero value.");
endmodule

bind inverse_distance_interpolator idw_checker u_idw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
